FILE: sv/indexed_array_list_top_assert.svh
// ----------------------------------------------------------------------------
// Indexed array list assertion macros
// Concurrent check helpers used by the array list top module.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_TOP_ASSERT_SVH
`define INDEXED_ARRAY_LIST_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define IAL_CHECK_IMPLY(label, clock, reset_n, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, masked during reset.
`define IAL_CHECK_NEXT(label, clock, reset_n, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (cond) |=> (expr)) else $error(msg);

`endif

FILE: sv/ial_pkg.sv
// ----------------------------------------------------------------------------
// Indexed array list package
// Sizes, request and status codes, sequencer states and word conversions.
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = 5;
    localparam int VAL_W      = 32;
    localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [2:0] {
        REQ_GET    = 3'd0,
        REQ_SET    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_PUSH   = 3'd4,
        REQ_POP    = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CAPTURE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        logic  re;
        addr_t raddr;
    } ram_req_t;

    typedef struct packed {
        logic               done;
        logic [VAL_W-1:0]   read_value;
        logic [IDX_W-1:0]   list_size;
        status_t            status;
    } rsp_t;

    function automatic word_t to_word(input logic signed [VAL_W-1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        return word_t'(x);
    endfunction

    function automatic logic [VAL_W-1:0] from_word(input word_t w);
        logic signed [63:0] x;
        x = 64'(signed'(w));
        return x[VAL_W-1:0];
    endfunction

endpackage

FILE: sv/indexed_array_list_top.sv
// ----------------------------------------------------------------------------
// Indexed array list
// Fixed-capacity list of signed words with get, set, insert, remove, push
// and pop; one result transaction per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req_valid / req_stall with req_type, index and value.
//   Response channel: rsp_valid / rsp_stall with read_value, list_size and
//   status (ok, full, empty, bad index). Failed requests leave the list as is.
//   Each request occupies the sequencer alone; req_stall is high until it
//   returns to idle. A failed request goes straight to finish; push writes
//   the entry; get, set and pop read and capture it; insert moves any
//   later entries up, then writes; remove reads and captures, then moves
//   any later entries down. Each moved entry costs a read and a write on
//   the single storage memory port pair; that walk sets the rate.
//   The response sits in an output register; a new request is taken while
//   it waits, but the next response holds in the sequencer until the
//   receiver drops rsp_stall.
//   Reset empties the list (count zero); stored words need no clearing.
// ----------------------------------------------------------------------------
`include "indexed_array_list_top_assert.svh"

module indexed_array_list_top
    import ial_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [2:0]              req_type,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [VAL_W-1:0] value,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic signed [VAL_W-1:0] read_value,
    output logic [IDX_W-1:0]        list_size,
    output logic [1:0]              status
);

    ram_req_t         ram_req;
    word_t            rdata;
    rsp_t             rsp;
    logic             hold;
    logic             rsp_valid_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic [IDX_W-1:0] list_size_reg;
    status_t          status_reg;

    ial_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .index     (index),
        .value     (value),
        .hold      (hold),
        .rdata     (rdata),
        .ram_req   (ram_req),
        .rsp       (rsp)
    );

    ial_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (rdata)
    );

    assign hold = rsp_valid_reg && rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.done)
        begin
            read_value_reg <= rsp.read_value;
            list_size_reg  <= rsp.list_size;
            status_reg     <= rsp.status;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = signed'(read_value_reg);
    assign list_size  = list_size_reg;
    assign status     = status_reg;

    `IAL_CHECK_IMPLY(a_size_in_range, clk, rst_n, rsp_valid, (32'(list_size) <= CAPACITY), "list size beyond capacity")
    `IAL_CHECK_IMPLY(a_fail_reads_zero, clk, rst_n, rsp_valid && (status_reg != ST_OK), (read_value_reg == '0), "failed request returned data")
    `IAL_CHECK_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall, "request taken while sequencer idle")

endmodule

FILE: sv/ial_ram.sv
// ----------------------------------------------------------------------------
// Indexed array list storage
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ial_ram
    import ial_pkg::*;
(
    input  logic     clk,
    input  ram_req_t ram_req,
    output word_t    rdata
);

    word_t mem [CAPACITY];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        if (ram_req.re)
        begin
            rdata_reg <= mem[ram_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ial_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed array list sequencer
// Checks each request, walks the entry memory one move at a time and
// keeps the element count.
// ----------------------------------------------------------------------------
module ial_ctrl
    import ial_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [2:0]              req_type,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    hold,
    input  word_t                   rdata,
    output ram_req_t                ram_req,
    output rsp_t                    rsp
);

    state_t           state_reg, state_next;
    req_type_t        req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    word_t            val_reg, val_next;
    count_t           count_reg, count_next;
    addr_t            ptr_reg, ptr_next;
    logic [VAL_W-1:0] rd_reg, rd_next;
    status_t          st_reg, st_next;
    logic             rsp_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
        ptr_reg <= ptr_next;
        rd_reg  <= rd_next;
        st_reg  <= st_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        ram_req    = '0;
        rsp_done   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_type_t'(req_type);
                    idx_next   = index;
                    val_next   = to_word(value);
                    rd_next    = '0;
                    st_next    = ST_OK;
                    state_next = S_FINISH;
                    case (req_type_t'(req_type))
                        REQ_GET, REQ_SET:
                        begin
                            if (CMP_W'(index) < CMP_W'(count_reg))
                            begin
                                ptr_next   = ADDR_W'(index);
                                state_next = S_READ;
                            end
                            else
                            begin
                                st_next = ST_BADIDX;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                st_next = ST_FULL;
                            end
                            else if (CMP_W'(index) > CMP_W'(count_reg))
                            begin
                                st_next = ST_BADIDX;
                            end
                            else
                            begin
                                ptr_next = ADDR_W'(count_reg);
                                if (CMP_W'(index) == CMP_W'(count_reg))
                                begin
                                    state_next = S_WRITE;
                                end
                                else
                                begin
                                    state_next = S_SHIFT_RD;
                                end
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else if (CMP_W'(index) >= CMP_W'(count_reg))
                            begin
                                st_next = ST_BADIDX;
                            end
                            else
                            begin
                                ptr_next   = ADDR_W'(index);
                                state_next = S_READ;
                            end
                        end
                        REQ_PUSH:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = ADDR_W'(count_reg);
                                state_next = S_WRITE;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = ADDR_W'(count_reg - CNT_W'(1));
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            st_next = ST_BADIDX;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ptr_reg;
                state_next    = S_CAPTURE;
            end

            S_CAPTURE:
            begin
                rd_next    = from_word(rdata);
                state_next = S_FINISH;
                case (req_reg)
                    REQ_SET:
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = ptr_reg;
                        ram_req.wdata = val_reg;
                    end
                    REQ_POP:
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = ptr_reg;
                        ram_req.wdata = '0;
                        count_next    = count_reg - CNT_W'(1);
                    end
                    REQ_REMOVE:
                    begin
                        if ((CNT_W'(ptr_reg) + CNT_W'(1)) < count_reg)
                        begin
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_SHIFT_RD:
            begin
                ram_req.re = 1'b1;
                if (req_reg == REQ_INSERT)
                begin
                    ram_req.raddr = ptr_reg - ADDR_W'(1);
                end
                else
                begin
                    ram_req.raddr = ptr_reg + ADDR_W'(1);
                end
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                ram_req.wdata = rdata;
                if (req_reg == REQ_INSERT)
                begin
                    ptr_next = ptr_reg - ADDR_W'(1);
                    if (CMP_W'(ptr_reg - ADDR_W'(1)) == CMP_W'(idx_reg))
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                    if ((CNT_W'(ptr_reg) + CNT_W'(2)) < count_reg)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            S_WRITE:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                ram_req.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (!hold)
                begin
                    rsp_done   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp       = '{done:       rsp_done,
                         read_value: rd_reg,
                         list_size:  IDX_W'(count_reg),
                         status:     st_reg};

endmodule
